@@ rtl/xrbg_pkg.sv @@
// Package for the xoshiro random byte generator: constants and helper functions.
package xrbg_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned HALF_W  = WORD_W / 2;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned BYTES   = WORD_W / 8;

   // FNV-1a 64-bit
   localparam logic [WORD_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [WORD_W-1:0] FNV_PRIME = 64'h00000100000001b3;

   // SplitMix64
   localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

   // xoshiro256** shift and rotate amounts
   localparam int unsigned XS_SHIFT = 17;
   localparam int unsigned XS_ROT   = 45;
   localparam int unsigned OUT_ROT  = 7;

   // request codes
   localparam logic REQ_GENERATE = 1'b0;
   localparam logic REQ_KEY      = 1'b1;

   // rotate left by a constant amount
   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

   // keep the low cnt bytes, zero the rest
   function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < BYTES; i++) begin
         if (COUNT_W'(i) < cnt) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      byte_mask = m;
   endfunction

endpackage

@@ rtl/xoshiro_random_byte_generator_unit.sv @@
// Top level of the xoshiro256** random byte generator with SplitMix64 and FNV-1a seeding.
//
// Usage: items enter on the req_ channel (valid/stall). A generate item (req_type 0)
// with a byte count of 1..8 (counts above 8 act as 8, a count of 0 is dropped with no
// result) advances the generator once and returns one item on the rsp_ channel:
// the output word little-endian, bytes beyond the count zeroed. Key items
// (req_type 1) fold their byte into an FNV-1a hash and return nothing; the last key
// item reseeds the generator from the hash and resets the hash.
// The SplitMix64 and FNV-1a multiplies run on one 32x32 multiplier in three passes
// (low x low, low x high, high x low) under a small sequencer.
// Sequencing: a generate item passes through ST_GEN1 and ST_GEN2 before rsp_valid is
// registered, and the next item is taken once the sequencer is back in ST_IDLE. A key
// item with a byte runs the three multiplier passes; a reseed (after reset, a csr write or
// the last key item) runs four SplitMix64 steps, during which req_stall is high.
// Reset: synchronous, active high; it loads the hash basis and starts the reseed
// from seed 0. A csr write restarts the reseed from the written value.
// When the receiver stalls, the result holds in the output register; the next
// item may already be taken, and a following generate waits for the register.
module xoshiro_random_byte_generator_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [3:0]  req_byte_count,
   input  logic [7:0]  req_key_byte,
   input  logic        req_key_byte_present,
   input  logic        req_key_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_random_bytes,
   output logic [3:0]  rsp_valid_bytes
);

   localparam int unsigned W  = xrbg_pkg::WORD_W;
   localparam int unsigned HW = xrbg_pkg::HALF_W;
   localparam int unsigned CW = xrbg_pkg::COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_ADD,
      ST_MUL1,
      ST_MUL2,
      ST_MULK,
      ST_GEN1,
      ST_GEN2
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        idx_ff, idx_in;
   logic [W-1:0]      mix_ff, mix_in;
   logic [W-1:0]      hash_ff, hash_in;
   logic [W-1:0]      opa_ff, opa_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic              last_ff, last_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]      gen_ff [4];
   logic [W-1:0]      gen_in [4];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]      rsp_bytes_ff, rsp_bytes_in;
   logic [CW-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic [W-1:0]      mul_b;
   logic [HW-1:0]     mul_x, mul_y;
   logic [W-1:0]      mul_p;
   logic              mul_done;
   logic [W-1:0]      mix_sum;
   logic [W-1:0]      xs_t;
   logic [W-1:0]      out_rot;
   logic              req_fire;
   logic              rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_bytes = rsp_bytes_ff;
   assign rsp_valid_bytes  = rsp_cnt_ff;

   // shared multiplier: constant operand picked by state
   always_comb begin
      unique case (state_ff)
         ST_MUL1: mul_b = xrbg_pkg::SM_MUL1;
         ST_MUL2: mul_b = xrbg_pkg::SM_MUL2;
         ST_MULK: mul_b = xrbg_pkg::FNV_PRIME;
         default: mul_b = '0;
      endcase
   end

   // three passes give the low 64 bits of the 64x64 product
   always_comb begin
      case (phase_ff)
         2'd0:    begin mul_x = opa_ff[HW-1:0]; mul_y = mul_b[HW-1:0]; end
         2'd1:    begin mul_x = opa_ff[HW-1:0]; mul_y = mul_b[W-1:HW]; end
         default: begin mul_x = opa_ff[W-1:HW]; mul_y = mul_b[HW-1:0]; end
      endcase
      mul_p = W'(mul_x) * W'(mul_y);
      if (phase_ff == 2'd0) begin
         acc_in = mul_p;
      end else begin
         acc_in = acc_ff + {mul_p[HW-1:0], {HW{1'b0}}};
      end
      mul_done = (phase_ff == 2'd2);
   end

   assign mix_sum = mix_ff + xrbg_pkg::SM_GAMMA;
   assign xs_t    = gen_ff[1] << xrbg_pkg::XS_SHIFT;
   assign out_rot = xrbg_pkg::rotl(opa_ff, xrbg_pkg::OUT_ROT);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      mix_in       = mix_ff;
      hash_in      = hash_ff;
      opa_in       = opa_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      gen_in       = gen_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type == xrbg_pkg::REQ_GENERATE) begin
                  if (req_byte_count != '0) begin
                     cnt_in   = (req_byte_count > CW'(xrbg_pkg::BYTES)) ?
                                CW'(xrbg_pkg::BYTES) : req_byte_count;
                     state_in = ST_GEN1;
                  end
               end else if (req_key_byte_present) begin
                  opa_in   = hash_ff ^ W'(req_key_byte);
                  last_in  = req_key_last;
                  phase_in = 2'd0;
                  state_in = ST_MULK;
               end else if (req_key_last) begin
                  mix_in   = hash_ff;
                  hash_in  = xrbg_pkg::FNV_BASIS;
                  idx_in   = 2'd0;
                  state_in = ST_MIX_ADD;
               end
            end
         end
         // SplitMix64 step: advance, then first xor-shift
         ST_MIX_ADD: begin
            mix_in   = mix_sum;
            opa_in   = mix_sum ^ (mix_sum >> 30);
            phase_in = 2'd0;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            phase_in = phase_ff + 2'd1;
            if (mul_done) begin
               opa_in   = acc_in ^ (acc_in >> 27);
               phase_in = 2'd0;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            phase_in = phase_ff + 2'd1;
            if (mul_done) begin
               gen_in[idx_ff] = acc_in ^ (acc_in >> 31);
               phase_in       = 2'd0;
               idx_in         = idx_ff + 2'd1;
               state_in       = (idx_ff == 2'd3) ? ST_IDLE : ST_MIX_ADD;
            end
         end
         // FNV-1a multiply, then optional reseed
         ST_MULK: begin
            phase_in = phase_ff + 2'd1;
            if (mul_done) begin
               phase_in = 2'd0;
               if (last_ff) begin
                  mix_in   = acc_in;
                  hash_in  = xrbg_pkg::FNV_BASIS;
                  idx_in   = 2'd0;
                  state_in = ST_MIX_ADD;
               end else begin
                  hash_in  = acc_in;
                  state_in = ST_IDLE;
               end
            end
         end
         // state update; keep s1*5 for the output word
         ST_GEN1: begin
            opa_in    = gen_ff[1] + (gen_ff[1] << 2);
            gen_in[2] = gen_ff[2] ^ gen_ff[0] ^ xs_t;
            gen_in[3] = xrbg_pkg::rotl(gen_ff[3] ^ gen_ff[1], xrbg_pkg::XS_ROT);
            gen_in[1] = gen_ff[1] ^ gen_ff[2] ^ gen_ff[0];
            gen_in[0] = gen_ff[0] ^ gen_ff[3] ^ gen_ff[1];
            state_in  = ST_GEN2;
         end
         // form the output word once the output register is free
         ST_GEN2: begin
            if (rsp_free) begin
               rsp_bytes_in = (out_rot + (out_rot << 3)) & xrbg_pkg::byte_mask(cnt_ff);
               rsp_cnt_in   = cnt_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // seed write restarts the expansion
      if (csr_wr_en) begin
         mix_in   = csr_wr_data;
         idx_in   = 2'd0;
         phase_in = 2'd0;
         state_in = ST_MIX_ADD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MIX_ADD;
         phase_ff     <= 2'd0;
         idx_ff       <= 2'd0;
         mix_ff       <= '0;
         hash_ff      <= xrbg_pkg::FNV_BASIS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         mix_ff       <= mix_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opa_ff       <= opa_in;
      acc_ff       <= acc_in;
      last_ff      <= last_in;
      cnt_ff       <= cnt_in;
      gen_ff       <= gen_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the xoshiro random byte generator: table and random items.
module tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 48;   // longest silent work: key byte plus reseed
   localparam int HOLD_CYCLES   = 300;

   localparam logic OP_GEN = xrbg_pkg::REQ_GENERATE;
   localparam logic OP_KEY = xrbg_pkg::REQ_KEY;

   // one input item, fields in port order
   typedef struct packed {
      logic       typ;
      logic [3:0] cnt;
      logic [7:0] kbyte;
      logic       kpres;
      logic       klast;
   } req_item_type;

   // one expected result item
   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
   } word_due_type;

   // directed row: fix_vb nonzero types in the valid_bytes the block must give
   typedef struct {
      req_item_type item;
      logic [3:0]   fix_vb;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = OP_GEN;
   logic [3:0]  req_byte_count = '0;
   logic [7:0]  req_key_byte = '0;
   logic        req_key_byte_present = 1'b0;
   logic        req_key_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_random_bytes;
   logic [3:0]  rsp_valid_bytes;

   xoshiro_random_byte_generator_unit dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_byte_count       (req_byte_count),
      .req_key_byte         (req_key_byte),
      .req_key_byte_present (req_key_byte_present),
      .req_key_last         (req_key_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_random_bytes     (rsp_random_bytes),
      .rsp_valid_bytes      (rsp_valid_bytes)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [63:0]  xs_state [4];
   logic [63:0]  fnv_acc;
   word_due_type words_due [$];

   int fail_cnt = 0;
   int burst_left = 0;
   int gap_max = 0;
   bit hold_ask = 1'b0;
   bit hold_done = 1'b0;

   // directed items: extremes, every operation, each special case
   dir_row_type dir_tab [0:21] = '{
      '{'{OP_GEN, 4'd1,  8'h00, 1'b0, 1'b0}, 4'd1},
      '{'{OP_GEN, 4'd8,  8'h00, 1'b0, 1'b0}, 4'd8},
      '{'{OP_GEN, 4'd0,  8'h00, 1'b0, 1'b0}, 4'd0},  // zero count: no item
      '{'{OP_GEN, 4'd15, 8'hff, 1'b1, 1'b1}, 4'd8},  // saturates, key fields ignored
      '{'{OP_GEN, 4'd9,  8'h00, 1'b0, 1'b0}, 4'd8},
      '{'{OP_GEN, 4'd2,  8'hff, 1'b1, 1'b1}, 4'd2},
      '{'{OP_GEN, 4'd3,  8'h00, 1'b0, 1'b0}, 4'd3},
      '{'{OP_GEN, 4'd4,  8'h00, 1'b0, 1'b0}, 4'd4},
      '{'{OP_GEN, 4'd5,  8'h00, 1'b0, 1'b0}, 4'd5},
      '{'{OP_GEN, 4'd6,  8'h00, 1'b0, 1'b0}, 4'd6},
      '{'{OP_GEN, 4'd7,  8'h00, 1'b0, 1'b0}, 4'd7},
      '{'{OP_KEY, 4'd15, 8'h00, 1'b1, 1'b0}, 4'd0},  // count ignored on key
      '{'{OP_KEY, 4'd0,  8'hff, 1'b1, 1'b0}, 4'd0},
      '{'{OP_KEY, 4'd8,  8'h5a, 1'b0, 1'b0}, 4'd0},  // no byte: hash unchanged
      '{'{OP_KEY, 4'd0,  8'ha5, 1'b1, 1'b1}, 4'd0},  // reseed from key
      '{'{OP_GEN, 4'd8,  8'h00, 1'b0, 1'b0}, 4'd8},
      '{'{OP_KEY, 4'd3,  8'hff, 1'b0, 1'b1}, 4'd0},  // empty key: seed from basis
      '{'{OP_GEN, 4'd8,  8'h00, 1'b0, 1'b0}, 4'd8},
      '{'{OP_KEY, 4'd0,  8'hff, 1'b1, 1'b1}, 4'd0},  // one-byte key
      '{'{OP_GEN, 4'd1,  8'h00, 1'b0, 1'b0}, 4'd1},
      '{'{OP_GEN, 4'd14, 8'h00, 1'b0, 1'b0}, 4'd8},
      '{'{OP_GEN, 4'd0,  8'hff, 1'b1, 1'b1}, 4'd0}
   };

   // one SplitMix64 step on the running accumulator
   function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
      logic [63:0] z;
      acc = acc + xrbg_pkg::SM_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * xrbg_pkg::SM_MUL1;
      z = (z ^ (z >> 27)) * xrbg_pkg::SM_MUL2;
      return z ^ (z >> 31);
   endfunction

   task automatic expand_seed(input logic [63:0] s);
      logic [63:0] acc;
      acc = s;
      for (int i = 0; i < 4; i++) begin
         xs_state[i] = splitmix_next(acc);
      end
   endtask

   // xoshiro256** output and state advance
   task automatic advance_xoshiro(output logic [63:0] w);
      logic [63:0] m5, t;
      m5 = xs_state[1] * 64'd5;
      w = {m5[56:0], m5[63:57]} * 64'd9;
      t = xs_state[1] << 17;
      xs_state[2] ^= xs_state[0];
      xs_state[3] ^= xs_state[1];
      xs_state[1] ^= xs_state[2];
      xs_state[0] ^= xs_state[3];
      xs_state[2] ^= t;
      xs_state[3] = {xs_state[3][18:0], xs_state[3][63:19]};
   endtask

   // apply one accepted item to the predictor, queue its word if any
   task automatic apply_item(input req_item_type it, input logic [3:0] fix_vb);
      logic [63:0]  w;
      logic [3:0]   n;
      word_due_type e;
      if (it.typ == OP_GEN) begin
         if (it.cnt != 4'd0) begin
            n = (it.cnt > 4'd8) ? 4'd8 : it.cnt;
            advance_xoshiro(w);
            if (n < 4'd8) w &= (64'd1 << (8 * n)) - 64'd1;
            e.word = w;
            e.nbytes = (fix_vb != 4'd0) ? fix_vb : n;
            words_due.push_back(e);
         end
      end else begin
         if (it.kpres) fnv_acc = (fnv_acc ^ {56'd0, it.kbyte}) * xrbg_pkg::FNV_PRIME;
         if (it.klast) begin
            expand_seed(fnv_acc);
            fnv_acc = xrbg_pkg::FNV_BASIS;
         end
      end
   endtask

   // present one item, wait for acceptance, then maybe close the burst
   task automatic offer(input req_item_type it, input logic [3:0] fix_vb);
      int gap;
      req_valid <= 1'b1;
      req_type <= it.typ;
      req_byte_count <= it.cnt;
      req_key_byte <= it.kbyte;
      req_key_byte_present <= it.kpres;
      req_key_last <= it.klast;
      do @(posedge clock); while (req_stall);
      apply_item(it, fix_vb);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop sending, let every word arrive and the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] v);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      expand_seed(v);
   endtask

   function automatic req_item_type rand_gen_item();
      req_item_type it;
      int p;
      p = $urandom_range(0, 19);
      it.typ = OP_GEN;
      if (p == 0) it.cnt = 4'd0;
      else if (p < 3) it.cnt = 4'($urandom_range(9, 15));
      else it.cnt = 4'($urandom_range(1, 8));
      it.kbyte = 8'($urandom_range(0, 255));
      it.kpres = 1'($urandom_range(0, 1));
      it.klast = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic req_item_type rand_key_item(input logic last);
      req_item_type it;
      it.typ = OP_KEY;
      it.cnt = 4'($urandom_range(0, 15));
      it.kbyte = 8'($urandom_range(0, 255));
      it.kpres = ($urandom_range(0, 7) != 0);
      it.klast = last;
      return it;
   endfunction

   // mostly generate items and complete keys, some noise
   task automatic random_run(input int n_items, input int hold_at);
      req_item_type it;
      int done, pick, len;
      done = 0;
      while (done < n_items) begin
         if (hold_at >= 0 && done >= hold_at && !hold_ask) hold_ask = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            offer(rand_gen_item(), 4'd0);
            done++;
         end else if (pick < 92) begin
            len = $urandom_range(0, 6);
            repeat (len) begin
               offer(rand_key_item(1'b0), 4'd0);
               done++;
            end
            offer(rand_key_item(1'b1), 4'd0);
            done++;
         end else begin
            it = rand_key_item(1'b0);
            if (pick < 96) begin
               it.kpres = 1'b0;
            end else begin
               it = rand_gen_item();
               it.cnt = 4'd0;
            end
            offer(it, 4'd0);
            done++;
         end
      end
   endtask

   // stimulus
   initial begin
      req_item_type it;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      fnv_acc = xrbg_pkg::FNV_BASIS;
      expand_seed(64'd0);

      gap_max = 3;
      foreach (dir_tab[i]) offer(dir_tab[i].item, dir_tab[i].fix_vb);

      // all-ones seed, no sender idling; phase ends inside a key
      write_seed(64'hffff_ffff_ffff_ffff);
      gap_max = 0;
      random_run(100, -1);
      it = rand_key_item(1'b0);
      it.kpres = 1'b1;
      repeat (3) offer(it, 4'd0);

      // seed write mid-key keeps the hash; long receiver hold here
      write_seed(64'd0);
      gap_max = 8;
      random_run(100, 30);

      write_seed({$urandom, $urandom});
      random_run(50, -1);
      settle();
      random_run(50, -1);

      write_seed(64'h8000_0000_0000_0001);
      gap_max = 5;
      random_run(100, -1);

      settle();
      if (fail_cnt == 0 && words_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // receiver stall pattern plus one long hold-off
   logic [31:0] rx_tick = '0;
   int          hold_left = 0;
   always @(posedge clock) begin
      rx_tick++;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
         if (hold_left == 0) hold_done = 1'b1;
      end else if (hold_ask && !hold_done) begin
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_tick[8:7])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((rx_tick % 7) < 3);
         endcase
      end
   end

   task automatic log_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
      fail_cnt++;
      if (fail_cnt <= 10) begin
         $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      word_due_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            log_mismatch("unexpected item", 64'd0, rsp_random_bytes);
         end else begin
            e = words_due.pop_front();
            if (rsp_random_bytes !== e.word)
               log_mismatch("random_bytes", e.word, rsp_random_bytes);
            if (rsp_valid_bytes !== e.nbytes)
               log_mismatch("valid_bytes", 64'(e.nbytes), 64'(rsp_valid_bytes));
         end
      end
   end

   // run limit
   int cycle_cnt = 0;
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule

@@ xoshiro_random_byte_generator_unit.f @@
rtl/xrbg_pkg.sv
rtl/xoshiro_random_byte_generator_unit.sv
verif/tb.sv
